// ===== rtl/core/asdt_pkg.sv =====
`default_nettype none

package asdt_pkg;

    // Ethertype of ARP frames
    localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;

    // Command codes
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_NOT_ARP    = 3'd0;
    localparam logic [2:0] ST_ADDED      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_READ_OK    = 3'd4;
    localparam logic [2:0] ST_NOT_FILLED = 3'd5;

    // Input item
    typedef struct packed {
        logic        command;
        logic [15:0] frame_type;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [7:0]  read_index;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_index;
        logic [47:0] entry_mac;
        logic [31:0] entry_ip;
        logic [8:0]  stations_stored;
    } rsp_item_t;

    // One stored table entry
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/arp_sender_dedup_table_unit.sv =====
`default_nettype none

// ARP sender station table. Each item on req is either an observe (command 0)
// carrying a frame's ethertype, sender MAC and sender IP, or a read (command 1)
// of a stored entry by index; each gives exactly one item on rsp. The entries
// sit in one synchronous RAM of TABLE_DEPTH words; an ARP observe scans the
// filled entries one per cycle, stopping at the first matching MAC, and
// appends the MAC and IP when no match is found and room is left. Items are
// handled one at a time; an ARP observe walks the table through the single
// RAM read port. Entries are cleared by no pass after reset; only filled
// entries are ever read. The result register lets a new item enter while the
// previous result waits on rsp_stall.
module arp_sender_dedup_table_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire asdt_pkg::req_item_t  req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output asdt_pkg::rsp_item_t       rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       cmp_reg, cmp_next;
    asdt_pkg::req_item_t cur_reg, cur_next;
    asdt_pkg::rsp_item_t res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    asdt_pkg::rsp_item_t rsp_reg, rsp_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    asdt_pkg::entry_t    mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    asdt_pkg::entry_t    mem_rdata;
    logic                match;

    asdt_ram #(
        .WIDTH ($bits(asdt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Compare the entry read in the previous scan cycle
    assign match = pend_reg && (mem_rdata.mac == cur_reg.sender_mac);

    // Sequence one item through the table
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        cmp_next       = cmp_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[AW-1:0];
        mem_wdata      = '{mac: cur_reg.sender_mac, ip: cur_reg.sender_ip};
        mem_re         = 1'b0;
        mem_raddr      = scan_reg[AW-1:0];

        // Drop the result once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next = req;
                    if (req.command == asdt_pkg::CMD_READ)
                    begin
                        if (32'(req.read_index) < 32'(fill_reg))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(req.read_index);
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            res_next   = '{status: asdt_pkg::ST_NOT_FILLED, default: '0};
                            state_next = S_FINISH;
                        end
                    end
                    else if (req.frame_type != asdt_pkg::ARP_ETHERTYPE)
                    begin
                        res_next   = '{status: asdt_pkg::ST_NOT_ARP, default: '0};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_RDWAIT:
            begin
                res_next = '{status:          asdt_pkg::ST_READ_OK,
                             entry_index:     cur_reg.read_index,
                             entry_mac:       mem_rdata.mac,
                             entry_ip:        mem_rdata.ip,
                             stations_stored: '0};
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                priority if (match)
                begin
                    res_next = '{status:          asdt_pkg::ST_DUPLICATE,
                                 entry_index:     8'(cmp_reg),
                                 entry_mac:       mem_rdata.mac,
                                 entry_ip:        mem_rdata.ip,
                                 stations_stored: '0};
                    state_next = S_FINISH;
                end
                else if (scan_reg < fill_reg)
                begin
                    // Advance the scan by one entry
                    mem_re    = 1'b1;
                    mem_raddr = scan_reg[AW-1:0];
                    cmp_next  = scan_reg[AW-1:0];
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (fill_reg == CW'(TABLE_DEPTH))
                begin
                    res_next   = '{status: asdt_pkg::ST_FULL, default: '0};
                    state_next = S_FINISH;
                end
                else
                begin
                    // Append the new station
                    mem_we   = 1'b1;
                    res_next = '{status:          asdt_pkg::ST_ADDED,
                                 entry_index:     8'(fill_reg),
                                 entry_mac:       cur_reg.sender_mac,
                                 entry_ip:        cur_reg.sender_ip,
                                 stations_stored: '0};
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hand the result to the output register when it is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next                 = res_reg;
                    rsp_next.stations_stored = 9'(fill_reg);
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_reg <= cmp_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // Fill count never passes the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= TABLE_DEPTH)
        else $error("fill count beyond table depth");

    // A write happens only with room left, and bumps the count by one
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(fill_reg) < TABLE_DEPTH))
        else $error("write into a full table");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance after append");

    // A duplicate result carries the MAC that was searched for
    a_dup_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_reg.status == asdt_pkg::ST_DUPLICATE)
        |-> (res_reg.entry_mac == cur_reg.sender_mac))
        else $error("duplicate result with mismatching MAC");

    // The scan never reads past the filled part of the table
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_re) |-> (scan_reg < fill_reg))
        else $error("scan read beyond filled entries");

endmodule

`default_nettype wire

// ===== rtl/core/asdt_ram.sv =====
`default_nettype none

module asdt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
